// ===== rtl/core/sai_pkg.sv =====
// Shared types and constants for the sorted array insert and remove block.
`timescale 1ns / 1ps

package sai_pkg;

  // Request codes
  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_LOOKUP = 2'd1;
  localparam logic [1:0] MODE_REMOVE = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  // Field widths fixed by the word formats
  localparam int ITEM_W  = 32;
  localparam int IDX_W   = 6;
  localparam int CNT_W   = 7;
  localparam int MODE_W  = 2;
  localparam int ST_W    = 2;
  localparam int IN_DW   = 40;
  localparam int OUT_DW  = 40;

  // Configuration port
  localparam int               CFG_AW    = 3;
  localparam int               CFG_DW    = 32;
  localparam logic [CNT_W-1:0] CAP_RESET = 7'd64;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_INS,
    S_PUT,
    S_LOOK,
    S_REM,
    S_DONE
  } sai_state_t;

  typedef enum logic [2:0] {
    J_HOLD,
    J_TOP,
    J_IDX,
    J_IDX1,
    J_INC,
    J_DEC
  } sai_jop_t;

  typedef enum logic [2:0] {
    WR_NONE,
    WR_UP,
    WR_ITEM_UP,
    WR_ITEM0,
    WR_DN
  } sai_wrop_t;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_DEC
  } sai_cntop_t;

  typedef struct packed {
    logic             take;
    sai_jop_t         j_op;
    sai_wrop_t        wr_op;
    sai_cntop_t       cnt_op;
    logic             st_set;
    logic [ST_W-1:0]  st_val;
    logic             val_cap;
    logic             out_load;
  } sai_cmd_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              full;
    logic              idx_ok;
    logic              cnt_zero;
    logic              idx_last;
    logic              j_zero;
    logic              j_last;
    logic              lt;
    logic [CNT_W-1:0]  count;
  } sai_stat_t;

endpackage

// ===== rtl/core/sai_dp.sv =====
// Datapath: entry memory, scan pointer, count and result registers.
`timescale 1ns / 1ps

module sai_dp import sai_pkg::*; #(
  parameter int DEPTH       = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [MODE_W-1:0] in_mode,
  input  logic [ITEM_W-1:0] in_item,
  input  logic [IDX_W-1:0]  in_idx,
  input  logic [CNT_W-1:0]  cap,
  input  sai_cmd_t          cmd,
  output sai_stat_t         stat,
  output logic [ITEM_W-1:0] out_val,
  output logic [CNT_W-1:0]  out_cnt,
  output logic [ST_W-1:0]   out_st
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [VALUE_WIDTH-1:0] mem [DEPTH];

  logic [VALUE_WIDTH-1:0] rd_data_r;
  logic [VALUE_WIDTH-1:0] item_r;
  logic [MODE_W-1:0]      mode_r;
  logic [IDX_W-1:0]       idx_r;
  logic [AW-1:0]          j_r, j_nxt;
  logic [CNT_W-1:0]       count_r, count_nxt;
  logic [CNT_W-1:0]       count_m1;
  logic [AW-1:0]          top_a;
  logic [VALUE_WIDTH-1:0] res_val_r;
  logic [ST_W-1:0]        res_st_r;
  logic [ITEM_W-1:0]      out_val_r;
  logic [CNT_W-1:0]       out_cnt_r;
  logic [ST_W-1:0]        out_st_r;

  logic                   wr_en;
  logic [AW-1:0]          wr_addr;
  logic [VALUE_WIDTH-1:0] wr_data;

  assign count_m1 = count_r - 7'd1;
  assign top_a    = AW'(count_m1);

  always_comb begin
    case (cmd.j_op)
      J_HOLD:  j_nxt = j_r;
      J_TOP:   j_nxt = top_a;
      J_IDX:   j_nxt = AW'(idx_r);
      J_IDX1:  j_nxt = AW'({1'b0, idx_r} + 7'd1);
      J_INC:   j_nxt = j_r + 1'b1;
      J_DEC:   j_nxt = j_r - 1'b1;
      default: j_nxt = j_r;
    endcase
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = j_r;
    wr_data = rd_data_r;
    case (cmd.wr_op)
      WR_NONE: begin
        wr_en = 1'b0;
      end
      WR_UP: begin
        wr_en   = 1'b1;
        wr_addr = j_r + 1'b1;
      end
      WR_ITEM_UP: begin
        wr_en   = 1'b1;
        wr_addr = j_r + 1'b1;
        wr_data = item_r;
      end
      WR_ITEM0: begin
        wr_en   = 1'b1;
        wr_addr = '0;
        wr_data = item_r;
      end
      WR_DN: begin
        wr_en   = 1'b1;
        wr_addr = j_r - 1'b1;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_comb begin
    case (cmd.cnt_op)
      CNT_HOLD: count_nxt = count_r;
      CNT_INC:  count_nxt = count_r + 7'd1;
      CNT_DEC:  count_nxt = count_m1;
      default:  count_nxt = count_r;
    endcase
  end

  // Single write port plus one registered read at the next pointer value
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[j_nxt];
  end

  always_ff @(posedge clk) begin
    j_r <= j_nxt;
    if (cmd.take) begin
      mode_r <= in_mode;
      item_r <= VALUE_WIDTH'(in_item);
      idx_r  <= in_idx;
    end
    if (cmd.take) begin
      res_val_r <= '0;
      res_st_r  <= ST_OK;
    end else begin
      if (cmd.val_cap) begin
        res_val_r <= rd_data_r;
      end
      if (cmd.st_set) begin
        res_st_r <= cmd.st_val;
      end
    end
    if (cmd.out_load) begin
      out_val_r <= ITEM_W'(res_val_r);
      out_cnt_r <= count_r;
      out_st_r  <= res_st_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  assign stat.mode     = mode_r;
  assign stat.full     = (count_r >= cap) || (32'(count_r) >= DEPTH);
  assign stat.idx_ok   = {1'b0, idx_r} < count_r;
  assign stat.cnt_zero = (count_r == '0);
  assign stat.idx_last = ({1'b0, idx_r} == count_m1);
  assign stat.j_zero   = (j_r == '0);
  assign stat.j_last   = (j_r == top_a);
  assign stat.lt       = (rd_data_r < item_r);
  assign stat.count    = count_r;

  assign out_val = out_val_r;
  assign out_cnt = out_cnt_r;
  assign out_st  = out_st_r;

endmodule

// ===== rtl/core/sai_ctrl.sv =====
// Controller: request sequencing and output word handshake.
`timescale 1ns / 1ps

module sai_ctrl import sai_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  input  logic      out_tready,
  input  sai_stat_t stat,
  output logic      in_tready,
  output logic      out_tvalid,
  output sai_cmd_t  cmd
);

  sai_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_tready;
    in_tready     = 1'b0;
    cmd           = '{take: 1'b0, j_op: J_HOLD, wr_op: WR_NONE, cnt_op: CNT_HOLD,
                      st_set: 1'b0, st_val: ST_OK, val_cap: 1'b0, out_load: 1'b0};
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.take  = 1'b1;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        case (stat.mode)
          MODE_INSERT: begin
            if (stat.full) begin
              cmd.st_set = 1'b1;
              cmd.st_val = ST_FULL;
              state_nxt  = S_DONE;
            end else if (stat.cnt_zero) begin
              cmd.wr_op  = WR_ITEM0;
              cmd.cnt_op = CNT_INC;
              state_nxt  = S_DONE;
            end else begin
              cmd.j_op  = J_TOP;
              state_nxt = S_INS;
            end
          end
          MODE_LOOKUP: begin
            if (stat.idx_ok) begin
              cmd.j_op  = J_IDX;
              state_nxt = S_LOOK;
            end else begin
              cmd.st_set = 1'b1;
              cmd.st_val = ST_RANGE;
              state_nxt  = S_DONE;
            end
          end
          MODE_REMOVE: begin
            if (!stat.idx_ok) begin
              cmd.st_set = 1'b1;
              cmd.st_val = ST_RANGE;
              state_nxt  = S_DONE;
            end else if (stat.idx_last) begin
              cmd.cnt_op = CNT_DEC;
              state_nxt  = S_DONE;
            end else begin
              cmd.j_op  = J_IDX1;
              state_nxt = S_REM;
            end
          end
          default: begin
            cmd.st_set = 1'b1;
            cmd.st_val = ST_RANGE;
            state_nxt  = S_DONE;
          end
        endcase
      end
      S_INS: begin
        if (stat.lt) begin
          cmd.wr_op  = WR_ITEM_UP;
          cmd.cnt_op = CNT_INC;
          state_nxt  = S_DONE;
        end else begin
          cmd.wr_op = WR_UP;
          if (stat.j_zero) begin
            state_nxt = S_PUT;
          end else begin
            cmd.j_op = J_DEC;
          end
        end
      end
      S_PUT: begin
        cmd.wr_op  = WR_ITEM0;
        cmd.cnt_op = CNT_INC;
        state_nxt  = S_DONE;
      end
      S_LOOK: begin
        cmd.val_cap = 1'b1;
        state_nxt   = S_DONE;
      end
      S_REM: begin
        cmd.wr_op = WR_DN;
        if (stat.j_last) begin
          cmd.cnt_op = CNT_DEC;
          state_nxt  = S_DONE;
        end else begin
          cmd.j_op = J_INC;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_tvalid = out_valid_r;

endmodule

// ===== rtl/core/sorted_array_insert_remove.sv =====
// Top level of the sorted array store with insert, lookup and remove.
//
//   channel   dir   handshake               contents
//   in_*      in    in_tvalid/in_tready     tdata: item_value, entry_index; tuser: mode
//   out_*     out   out_tvalid/out_tready   tdata: read_value, entry_count; tuser: status
//   cfg_*     in    psel/penable/pready     capacity register at byte address 0
//
// One request at a time. Errors, an insert into an empty store and a remove of the last
// entry go from the decide state straight to the done state; a lookup first reads the entry;
// an insert shifts up each stored entry at or above the new value, and a remove shifts down
// each entry above the removed index, as the memory moves one entry per cycle.
// Reset clears the count and sets capacity to 64; the memory needs no clearing pass.
// A result waiting on out_tready does not block the next request from being taken.
`timescale 1ns / 1ps

module sorted_array_insert_remove import sai_pkg::*; #(
  parameter int DEPTH       = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  // request words
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [IN_DW-1:0]  in_tdata,   // item_value[31:0], entry_index[37:32], zero pad
  input  logic [MODE_W-1:0] in_tuser,   // mode[1:0]
  // result words
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_DW-1:0] out_tdata,  // read_value[31:0], entry_count[38:32], zero pad
  output logic [ST_W-1:0]   out_tuser,  // status[1:0]
  // register port
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  sai_cmd_t          cmd;
  sai_stat_t         stat;
  logic [CNT_W-1:0]  cap_r;
  logic [ITEM_W-1:0] res_val;
  logic [CNT_W-1:0]  res_cnt;
  logic              cfg_wr;

  // Capacity register: selected while address bit 2 is clear; addresses 4 to 7 are unmapped
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_wr && !cfg_paddr[2]) begin
      cap_r <= cfg_pwdata[CNT_W-1:0];
    end
  end

  assign cfg_prdata = cfg_paddr[2] ? '0 : CFG_DW'(cap_r);

  // Sequencer: walks the shift loop one entry per cycle
  sai_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .cmd        (cmd)
  );

  // Entry memory, pointer, count and the output register
  sai_dp #(
    .DEPTH       (DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_mode (in_tuser),
    .in_item (in_tdata[ITEM_W-1:0]),
    .in_idx  (in_tdata[ITEM_W+IDX_W-1:ITEM_W]),
    .cap     (cap_r),
    .cmd     (cmd),
    .stat    (stat),
    .out_val (res_val),
    .out_cnt (res_cnt),
    .out_st  (out_tuser)
  );

  assign out_tdata = {1'b0, res_cnt, res_val};

`ifndef ASSERT_OFF
  // Taking a request always leaves the block not ready in the following cycle
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request taken while previous one still in progress");

  // Failed requests never carry a read value
  a_err_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != ST_OK |-> out_tdata[ITEM_W-1:0] == '0)
    else $error("error result with nonzero read value");

  // The count moves by at most one entry per cycle
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (stat.count == $past(stat.count) ||
                      stat.count == 7'($past(stat.count) + 7'd1) ||
                      stat.count == 7'($past(stat.count) - 7'd1)))
    else $error("entry count jumped");

  // The count never exceeds the built depth
  a_count_depth: assert property (@(posedge clk) disable iff (!rst_n)
    32'(stat.count) <= DEPTH)
    else $error("entry count above depth");
`endif

endmodule
